>>> rtl/ipd_pkg.sv
// Shared types and constants for the interrupt priority delivery block.
`default_nettype none

package ipd_pkg;

    // Sizes of the interrupt domain.
    localparam int SRC_COUNT  = 63;
    localparam int HART_COUNT = 4;
    localparam int PRIO_BITS  = 8;

    // Field widths of the stream items.
    localparam int KIND_W   = 3;
    localparam int SRC_W    = 6;
    localparam int HART_W   = 2;
    localparam int LEVEL_W  = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Source table depth, one entry per source number.
    localparam int SRC_DEPTH = 1 << SRC_W;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DOMAIN_ENABLE = 1'b0;
    localparam logic REG_HART_MASK     = 1'b1;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TARGET    = 3'd0,
        KIND_PENDING   = 3'd1,
        KIND_ENABLE    = 3'd2,
        KIND_HART_CTRL = 3'd3,
        KIND_READ_HART = 3'd4
    } ipd_kind_t;

    // One source table entry.
    typedef struct packed {
        logic [HART_W-1:0]  target;
        logic [LEVEL_W-1:0] prio;
        logic               pend;
        logic               en;
    } ipd_entry_t;

    localparam ipd_entry_t ENTRY_RESET = '{target: '0, prio: LEVEL_W'(1), pend: 1'b0, en: 1'b0};

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_APPLY,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ipd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_item;
        logic apply;
        logic scan_rd;
        logic finish;
    } ipd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } ipd_sts_t;

endpackage

`default_nettype wire

>>> rtl/ipd_ctrl.sv
// Controller state machine that sequences one item through update and scan.
`default_nettype none

module ipd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire ipd_pkg::ipd_sts_t sts,
    output ipd_pkg::ipd_cmd_t      cmd
);
    import ipd_pkg::*;

    ipd_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // State and output-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_item = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register holds a result until its transfer completes.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> rtl/ipd_datapath.sv
// Datapath: source table memory, hart registers, priority scan and result register.
`default_nettype none

module ipd_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ipd_pkg::ipd_cmd_t              cmd,
    output ipd_pkg::ipd_sts_t                   sts,
    input  wire logic [ipd_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [ipd_pkg::KIND_W-1:0]     s_tuser,
    input  wire logic                           domain_enable,
    input  wire logic [ipd_pkg::HART_COUNT-1:0] hart_mask,
    output logic [ipd_pkg::M_DATA_W-1:0]        m_tdata
);
    import ipd_pkg::*;

    // Captured item.
    logic [KIND_W-1:0]  kind_reg;
    logic [SRC_W-1:0]   src_reg;
    logic [HART_W-1:0]  hart_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic               bit_reg;
    logic               dlv_in_reg;
    logic               frc_in_reg;
    logic [HART_W-1:0]  rep_reg, rep_next;

    // Source table and its read port.
    ipd_entry_t             src_mem [SRC_DEPTH];
    logic [SRC_DEPTH-1:0]   src_vld_reg;
    ipd_entry_t             rd_entry_reg;
    logic                   rd_vld_reg;
    logic [SRC_W-1:0]       rd_addr;
    ipd_entry_t             entry;
    ipd_entry_t             wr_entry;
    logic                   src_ok;
    logic                   mem_we;

    // Hart registers.
    logic [LEVEL_W-1:0]    thr_reg      [HART_COUNT];
    logic [HART_COUNT-1:0] dlv_reg;
    logic [HART_COUNT-1:0] frc_reg;
    logic [HART_COUNT-1:0] line_reg;
    logic                  hart_ok;

    // Scan state and running winners.
    logic [SRC_W-1:0]   scan_idx_reg;
    logic [SRC_W-1:0]   eval_idx_reg;
    logic               eval_reg;
    logic [SRC_W-1:0]   top_src_reg  [HART_COUNT];
    logic [LEVEL_W-1:0] top_prio_reg [HART_COUNT];
    logic               win;
    logic [LEVEL_W-1:0] th;
    logic [HART_W-1:0]  eh;

    // Line computation and result.
    logic [HART_COUNT-1:0] new_line;
    logic [HART_COUNT-1:0] changed;
    logic [M_DATA_W-1:0]   out_data_reg;

    // Capture the item fields on the input transfer.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_tuser;
            src_reg    <= s_tdata[5:0];
            hart_reg   <= s_tdata[7:6];
            lvl_reg    <= s_tdata[15:8];
            bit_reg    <= s_tdata[16];
            dlv_in_reg <= s_tdata[17];
            frc_in_reg <= s_tdata[18];
        end
        rep_reg <= rep_next;
    end

    assign src_ok  = (src_reg != '0) && (32'(src_reg) <= SRC_COUNT);
    assign hart_ok = 32'(hart_reg) < HART_COUNT;

    // Entry as seen through the valid bits: never written reads as reset value.
    assign entry = rd_vld_reg ? rd_entry_reg : ENTRY_RESET;

    // Reported hart: the item's hart, or the addressed source's target.
    always_comb begin
        rep_next = rep_reg;
        if (cmd.capture) begin
            rep_next = s_tdata[7:6];
        end else if (cmd.apply && (kind_reg == KIND_PENDING || kind_reg == KIND_ENABLE)) begin
            rep_next = src_ok ? entry.target : '0;
        end
    end

    // Merged entry for the read-modify-write of the source table.
    always_comb begin
        wr_entry = entry;
        mem_we   = 1'b0;
        case (kind_reg)
            KIND_TARGET: begin
                mem_we          = cmd.apply && src_ok;
                wr_entry.target = hart_reg;
                wr_entry.prio   = (lvl_reg[PRIO_BITS-1:0] == '0) ? LEVEL_W'(1)
                                                                 : LEVEL_W'(lvl_reg[PRIO_BITS-1:0]);
            end
            KIND_PENDING: begin
                mem_we        = cmd.apply && src_ok;
                wr_entry.pend = bit_reg;
            end
            KIND_ENABLE: begin
                mem_we      = cmd.apply && src_ok;
                wr_entry.en = bit_reg;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign rd_addr = cmd.rd_item ? src_reg : scan_idx_reg;

    // Source table memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            src_mem[src_reg] <= wr_entry;
        end
        rd_entry_reg <= src_mem[rd_addr];
        rd_vld_reg   <= src_vld_reg[rd_addr];
    end

    // Written-entry marks, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_vld_reg <= '0;
        end else if (mem_we) begin
            src_vld_reg[src_reg] <= 1'b1;
        end
    end

    // Hart control registers and interrupt lines.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < HART_COUNT; h++) begin
                thr_reg[h] <= '0;
            end
            dlv_reg  <= '0;
            frc_reg  <= '0;
            line_reg <= '0;
        end else begin
            if (cmd.apply && kind_reg == KIND_HART_CTRL && hart_ok) begin
                thr_reg[hart_reg] <= LEVEL_W'(lvl_reg[PRIO_BITS-1:0]);
                dlv_reg[hart_reg] <= dlv_in_reg;
                frc_reg[hart_reg] <= frc_in_reg;
            end
            if (cmd.finish) begin
                line_reg <= new_line;
            end
        end
    end

    // Scan index walks sources 1 to SRC_COUNT; each read lands in the cycle after it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_reg <= 1'b0;
        end else begin
            eval_reg <= cmd.scan_rd;
        end
        if (cmd.apply) begin
            scan_idx_reg <= SRC_W'(1);
        end else if (cmd.scan_rd) begin
            scan_idx_reg <= scan_idx_reg + SRC_W'(1);
        end
        eval_idx_reg <= scan_idx_reg;
    end

    assign sts.scan_last = scan_idx_reg == SRC_W'(SRC_COUNT);

    // A scanned source wins its hart when it qualifies and beats the current
    // winner; ascending order keeps the lowest id on a tie.
    always_comb begin
        eh  = entry.target;
        th  = thr_reg[eh];
        win = eval_reg && hart_mask[eh] && entry.pend && entry.en &&
              (th == '0 || entry.prio < th) &&
              (top_src_reg[eh] == '0 || entry.prio < top_prio_reg[eh]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            for (int h = 0; h < HART_COUNT; h++) begin
                top_src_reg[h]  <= '0;
                top_prio_reg[h] <= '0;
            end
        end else if (win) begin
            top_src_reg[eh]  <= eval_idx_reg;
            top_prio_reg[eh] <= entry.prio;
        end
    end

    // New interrupt lines and the mask of those that change.
    always_comb begin
        for (int h = 0; h < HART_COUNT; h++) begin
            new_line[h] = domain_enable && hart_mask[h] && dlv_reg[h] &&
                          (frc_reg[h] || top_src_reg[h] != '0);
        end
        changed = new_line ^ line_reg;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {3'b000, changed, new_line[rep_reg],
                             top_prio_reg[rep_reg], top_src_reg[rep_reg], rep_reg};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/interrupt_priority_delivery.sv
// Top level: configuration registers, controller and datapath.
// Each item passes READ, APPLY, SCAN, DRAIN and DONE before its result is on m_tvalid.
// One item at a time: s_tready is high only in IDLE, so a new item is taken once the
// last result enters the output register; the scan reads sources 1 to 63 of the table.
// Reset: aresetn is synchronous and active low; it clears the source table
// marks, hart registers, lines and controller, with domain_enable 0 and hart_mask 15.
`default_nettype none

module interrupt_priority_delivery (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // source[5:0], hart[7:6], level[15:8], bit_value[16], deliver[17], force_req[18]
    input  wire logic [ipd_pkg::S_DATA_W-1:0]    s_tdata,
    // kind[2:0]
    input  wire logic [ipd_pkg::KIND_W-1:0]      s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // report_hart[1:0], top_source[7:2], top_priority[15:8], line_level[16],
    // changed_lines[20:17]
    output logic [ipd_pkg::M_DATA_W-1:0]         m_tdata,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ipd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ipd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ipd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import ipd_pkg::*;

    logic                  domain_enable_reg;
    logic [HART_COUNT-1:0] hart_mask_reg;
    logic                  reg_idx;
    logic                  cfg_wr;
    ipd_cmd_t              cmd;
    ipd_sts_t              sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            domain_enable_reg <= 1'b0;
            hart_mask_reg     <= '1;
        end else if (cfg_wr) begin
            if (reg_idx == REG_DOMAIN_ENABLE) begin
                domain_enable_reg <= pwdata[0];
            end else begin
                hart_mask_reg <= pwdata[HART_COUNT-1:0];
            end
        end
    end

    // Register read data.
    always_comb begin
        if (reg_idx == REG_HART_MASK) begin
            prdata = APB_DATA_W'(hart_mask_reg);
        end else begin
            prdata = APB_DATA_W'(domain_enable_reg);
        end
    end

    ipd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .domain_enable (domain_enable_reg),
        .hart_mask     (hart_mask_reg),
        .m_tdata       (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/ipd_checker.sv
// Port-level checker for the interrupt priority delivery block, with its bind.
`default_nettype none

module ipd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // One item at a time: after an input transfer the block is busy.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A winner always carries a nonzero priority, no winner a zero one.
    a_top_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:2] == 6'd0) == (m_tdata[15:8] == 8'd0)))
        else $error("top source and top priority disagree");

endmodule

bind interrupt_priority_delivery ipd_checker u_ipd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
